// ----- rtl/core/bba_pkg.sv -----
// Shared types, codes and defaults for the bitmap block allocator.
package bba_pkg;

  localparam int unsigned POOL_BLOCKS_DEF = 1024;
  localparam int unsigned MAX_REQUEST_DEF = 64;

  // Bitmap storage word: 32 blocks per RAM row.
  localparam int unsigned WORD_W = 32;
  localparam int unsigned BIT_W  = 5;

  localparam int unsigned OP_W  = 2;
  localparam int unsigned CNT_W = 7;
  localparam int unsigned ID_W  = 10;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned FC_W  = 11;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_COUNT = 2'd2;

  localparam logic [ST_W-1:0] ST_OK      = 2'd0;
  localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
  localparam logic [ST_W-1:0] ST_TOOBIG  = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [CNT_W-1:0] request_count;
    logic [ID_W-1:0]  release_id;
  } in_item_t;

  typedef struct packed {
    logic [ST_W-1:0] status;
    logic [ID_W-1:0] granted_block;
    logic            last;
    logic [FC_W-1:0] free_count;
  } out_item_t;

  // What an incoming transaction needs from the datapath.
  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_ALLOC,
    KIND_FREE
  } kind_e;

  typedef struct packed {
    logic clear_wr;
    logic accept;
    logic load_word;
    logic rd_next;
    logic scan_emit;
    logic free_wr;
    logic emit_single;
  } dp_cmd_t;

  typedef struct packed {
    kind_e in_kind;
    logic  clear_last;
    logic  word_full;
    logic  last_grant;
  } dp_sts_t;

endpackage

// ----- rtl/core/bitmap_block_allocator.sv -----
// Top level of the first-fit bitmap block allocator.
//
// Input channel (in_valid_i/in_ready_o/in_data_i): one transaction is an
// allocate, free or count request. Output channel (out_valid_o/out_ready_i/
// out_data_o): result transactions, the final one of each request has last
// set. One request is worked on at a time; in_ready_o is high only while
// the controller is idle, which it reaches as soon as a request's last
// result is loaded into the output register, even if that result waits.
// Sequence per request, with a ready receiver:
//   count, error or out-of-pool free: acceptance, then the result;
//   free: RAM read, then write-back, then the result;
//   allocate N: N results, with a RAM row read per bitmap word scanned,
//   the word scan over 32-bit RAM rows being the limiting loop (32 rows here).
// After reset the bitmap RAM is cleared one row per cycle, ceil(POOL_BLOCKS
// / 32) rows in all (32 at the default pool), with in_ready_o low meanwhile.
// A stalled receiver holds the output register; the scan waits on it.
module bitmap_block_allocator #(
  parameter int unsigned POOL_BLOCKS = bba_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned MAX_REQUEST = bba_pkg::MAX_REQUEST_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  bba_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output bba_pkg::out_item_t out_data_o
);
  import bba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer: clear pass, request dispatch, scan and result handshake.
  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Bitmap storage, free counter and result payload.
  bba_datapath #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .MAX_REQUEST(MAX_REQUEST)
  ) u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .out_data_o(out_data_o),
    .cmd_i     (cmd),
    .sts_o     (sts)
  );

endmodule

// ----- rtl/core/bba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int unsigned WIDTH  = 32,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/core/bba_ctrl.sv -----
// Controller state machine for the bitmap block allocator.
module bba_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  bba_pkg::dp_sts_t sts_i,
  output bba_pkg::dp_cmd_t cmd_o
);
  import bba_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_ALLOC,
    S_RD_FREE,
    S_SCAN,
    S_EMIT
  } state_e;

  state_e  state_q, state_d;
  logic    out_valid_q, out_valid_d;
  logic    slot_free;
  dp_cmd_t cmd;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (sts_i.clear_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.accept = 1'b1;
          case (sts_i.in_kind)
            KIND_ALLOC: state_d = S_RD_ALLOC;
            KIND_FREE:  state_d = S_RD_FREE;
            default:    state_d = S_EMIT;
          endcase
        end
      end
      S_RD_ALLOC: begin
        cmd.load_word = 1'b1;
        state_d       = S_SCAN;
      end
      S_RD_FREE: begin
        cmd.free_wr = 1'b1;
        state_d     = S_EMIT;
      end
      S_SCAN: begin
        if (sts_i.word_full) begin
          cmd.rd_next = 1'b1;
          state_d     = S_RD_ALLOC;
        end else if (slot_free) begin
          cmd.scan_emit = 1'b1;
          if (sts_i.last_grant) state_d = S_IDLE;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit_single = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.scan_emit || cmd.emit_single) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

endmodule

// ----- rtl/core/bba_datapath.sv -----
// Datapath: bitmap RAM, free counter, word scanner and result register.
module bba_datapath #(
  parameter int unsigned POOL_BLOCKS = bba_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned MAX_REQUEST = bba_pkg::MAX_REQUEST_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bba_pkg::in_item_t  in_data_i,
  output bba_pkg::out_item_t out_data_o,
  input  bba_pkg::dp_cmd_t   cmd_i,
  output bba_pkg::dp_sts_t   sts_o
);
  import bba_pkg::*;

  localparam int unsigned NUM_WORDS = (POOL_BLOCKS + WORD_W - 1) / WORD_W;
  localparam int unsigned ADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int unsigned FT_W      = $clog2(POOL_BLOCKS + 1);

  // Lowest clear bit of a bitmap word.
  function automatic logic [BIT_W-1:0] lowest_zero(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (!w[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  logic [ADDR_W-1:0] clr_q;
  logic [FT_W-1:0]   free_total_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [ADDR_W-1:0] waddr_q;
  logic [ADDR_W-1:0] id_addr_q;
  logic [BIT_W-1:0]  id_bit_q;
  logic [ST_W-1:0]   status_q;
  logic [WORD_W-1:0] word_q;
  out_item_t         out_q;

  // Classification of the incoming transaction
  logic [ST_W-1:0]   in_status;
  kind_e             in_kind;
  logic [31:0]       in_word_idx;
  logic [ADDR_W-1:0] in_addr;

  always_comb begin
    in_status = ST_OK;
    in_kind   = KIND_SINGLE;
    if (in_data_i.operation == OP_ALLOC) begin
      if (in_data_i.request_count == '0) begin
        in_status = ST_EMPTY;
      end else if (32'(in_data_i.request_count) > 32'(MAX_REQUEST)) begin
        in_status = ST_TOOBIG;
      end else if (32'(in_data_i.request_count) > 32'(free_total_q)) begin
        in_status = ST_NOSPACE;
      end else begin
        in_kind = KIND_ALLOC;
      end
    end else if (in_data_i.operation == OP_FREE) begin
      if (32'(in_data_i.release_id) < 32'(POOL_BLOCKS)) in_kind = KIND_FREE;
    end
  end

  assign in_word_idx = 32'(in_data_i.release_id) >> BIT_W;
  assign in_addr     = (in_kind == KIND_ALLOC) ? '0 : in_word_idx[ADDR_W-1:0];

  // Bitmap RAM ports
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [ADDR_W-1:0] ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic [BIT_W-1:0]  zero_idx;
  logic [WORD_W-1:0] zero_mask;
  logic [WORD_W-1:0] free_mask;
  logic              free_hit;
  logic [31:0]       grant_wide;

  assign zero_idx   = lowest_zero(word_q);
  assign zero_mask  = WORD_W'(1) << zero_idx;
  assign free_mask  = WORD_W'(1) << id_bit_q;
  assign free_hit   = |(ram_rdata & free_mask);
  assign grant_wide = (32'(waddr_q) << BIT_W) | 32'(zero_idx);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = waddr_q;
    ram_wdata = word_q | zero_mask;
    if (cmd_i.clear_wr) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
    end else if (cmd_i.scan_emit) begin
      ram_we = 1'b1;
    end else if (cmd_i.free_wr) begin
      ram_we    = free_hit;
      ram_waddr = id_addr_q;
      ram_wdata = ram_rdata & ~free_mask;
    end
  end

  always_comb begin
    if (cmd_i.accept) begin
      ram_raddr = in_addr;
    end else begin
      ram_raddr = waddr_q + ADDR_W'(1);
    end
  end

  bba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (NUM_WORDS),
    .ADDR_W(ADDR_W)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q        <= '0;
      free_total_q <= FT_W'(POOL_BLOCKS);
    end else begin
      if (cmd_i.clear_wr) clr_q <= clr_q + ADDR_W'(1);
      if (cmd_i.accept && in_kind == KIND_ALLOC) begin
        free_total_q <= free_total_q - FT_W'(in_data_i.request_count);
      end else if (cmd_i.free_wr && free_hit) begin
        free_total_q <= free_total_q + FT_W'(1);
      end
    end
  end

  // Working and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      status_q  <= in_status;
      cnt_q     <= in_data_i.request_count;
      waddr_q   <= '0;
      id_addr_q <= in_word_idx[ADDR_W-1:0];
      id_bit_q  <= in_data_i.release_id[BIT_W-1:0];
    end
    if (cmd_i.rd_next) waddr_q <= waddr_q + ADDR_W'(1);
    if (cmd_i.load_word) word_q <= ram_rdata;
    if (cmd_i.scan_emit) begin
      word_q              <= word_q | zero_mask;
      cnt_q               <= cnt_q - CNT_W'(1);
      out_q.status        <= ST_OK;
      out_q.granted_block <= grant_wide[ID_W-1:0];
      out_q.last          <= (cnt_q == CNT_W'(1));
      out_q.free_count    <= FC_W'(free_total_q);
    end
    if (cmd_i.emit_single) begin
      out_q.status        <= status_q;
      out_q.granted_block <= '0;
      out_q.last          <= 1'b1;
      out_q.free_count    <= FC_W'(free_total_q);
    end
  end

  assign sts_o.in_kind    = in_kind;
  assign sts_o.clear_last = (clr_q == ADDR_W'(NUM_WORDS - 1));
  assign sts_o.word_full  = &word_q;
  assign sts_o.last_grant = (cnt_q == CNT_W'(1));
  assign out_data_o       = out_q;

endmodule

// ----- dv/bba_result_checker.sv -----
// Checker for the bitmap block allocator: tracks the bitmap, predicts results, compares.
module bba_result_checker
  import bba_pkg::*;
#(
  parameter int unsigned POOL_BLOCKS = POOL_BLOCKS_DEF,
  parameter int unsigned MAX_REQUEST = MAX_REQUEST_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_item_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_item_t out_data_i,
  output int        pending_o,
  output int        errors_o
);

  localparam int REPORT_LIMIT = 10;

  logic [POOL_BLOCKS-1:0] block_used;
  logic [FC_W-1:0]        free_blocks;
  out_item_t              expected_results[$];
  out_item_t              want;
  int                     mismatches;

  // Applies one request transaction to the bitmap and queues its results.
  task automatic predict_request(input in_item_t req);
    out_item_t   res;
    int unsigned granted;
    int unsigned blk;
    res        = '0;
    res.status = ST_OK;
    res.last   = 1'b1;
    if (req.operation == OP_ALLOC) begin
      if (req.request_count == '0) begin
        res.status = ST_EMPTY;
      end else if (req.request_count > MAX_REQUEST) begin
        res.status = ST_TOOBIG;
      end else if (req.request_count > free_blocks) begin
        res.status = ST_NOSPACE;
      end else begin
        free_blocks = free_blocks - FC_W'(req.request_count);
        granted = 0;
        // first fit: lowest free ids, ascending
        for (blk = 0; blk < POOL_BLOCKS && granted < req.request_count; blk++) begin
          if (!block_used[blk]) begin
            block_used[blk]   = 1'b1;
            res.granted_block = ID_W'(blk);
            res.last          = (granted + 1 == req.request_count);
            res.free_count    = free_blocks;
            expected_results.insert(expected_results.size(), res);
            granted++;
          end
        end
        return;
      end
    end else if (req.operation == OP_FREE) begin
      // double free and out-of-pool ids leave the map alone
      if (req.release_id < POOL_BLOCKS && block_used[req.release_id]) begin
        block_used[req.release_id] = 1'b0;
        free_blocks = free_blocks + 1'b1;
      end
    end
    res.free_count = free_blocks;
    expected_results.insert(expected_results.size(), res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_used  = '0;
      free_blocks = FC_W'(POOL_BLOCKS);
      expected_results.delete();
      mismatches  = 0;
      pending_o  <= 0;
      errors_o   <= 0;
    end else begin
      // results first: one request in flight, so they never belong to this edge's input
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("unexpected result: status %0d block %0d last %0d free %0d",
                     out_data_i.status, out_data_i.granted_block, out_data_i.last,
                     out_data_i.free_count);
        end else begin
          want = expected_results.pop_front();
          if (out_data_i.status !== want.status ||
              out_data_i.granted_block !== want.granted_block ||
              out_data_i.last !== want.last ||
              out_data_i.free_count !== want.free_count) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display({"result mismatch: expected status %0d block %0d last %0d free %0d,",
                        " got status %0d block %0d last %0d free %0d"},
                       want.status, want.granted_block, want.last, want.free_count,
                       out_data_i.status, out_data_i.granted_block, out_data_i.last,
                       out_data_i.free_count);
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_request(in_data_i);
      pending_o <= expected_results.size();
      errors_o  <= mismatches;
    end
  end

endmodule

// ----- dv/tb_bitmap_block_allocator.sv -----
// Testbench top for the bitmap block allocator: stimulus, receiver, verdict.
module tb_bitmap_block_allocator;
  import bba_pkg::*;

  // Operation code 3 is not defined by the block; it must behave as a count query.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  localparam int RANDOM_ITEMS = 180;
  localparam int IDLE_PCT     = 14;
  localparam int HOLD_CYCLES  = 400;   // long receiver stall, forces input backpressure
  localparam int DRAIN_CYCLES = 100;
  // Worst case: every transaction with 64 results, each behind a receiver stall,
  // plus the bitmap clear after reset; taken a few times over.
  localparam int CYCLE_LIMIT  = 400000;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  logic      quiet;          // no idling on either side while set
  logic      hold_request;   // asks the receiver for its long stall
  int        pending;
  int        errors;
  int unsigned cycle_count = 0;

  bitmap_block_allocator dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  bba_result_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_data_i  (out_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver: random stalls, none while quiet, one long hold-off on request.
  // The hold is counted here so the sender keeps offering transactions meanwhile.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_request && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  function automatic in_item_t pack_request(input logic [OP_W-1:0]  op,
                                            input logic [CNT_W-1:0] cnt,
                                            input logic [ID_W-1:0]  id);
    in_item_t req;
    req.operation     = op;
    req.request_count = cnt;
    req.release_id    = id;
    return req;
  endfunction

  // Offers one request transaction; returns just after the edge that accepted it.
  // Valid stays high on return so back-to-back transactions need no extra toggle.
  task automatic send_request(input in_item_t req);
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 40);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk_i); while (!in_ready);
  endtask

  initial begin
    in_item_t    req;
    int unsigned pick;
    rst_ni       = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // The block clears its bitmap after reset; in_ready stays low until done.

    // Directed: error codes, boundary sizes, double frees, unused op, pool exhaustion.
    send_request(pack_request(OP_COUNT, 7'd0, 10'd0));         // full pool count
    send_request(pack_request(OP_ALLOC, 7'd0, 10'd1023));      // empty request
    send_request(pack_request(OP_ALLOC, 7'd65, 10'd0));        // just over the limit
    send_request(pack_request(OP_ALLOC, 7'd127, 10'd0));       // widest count field
    send_request(pack_request(OP_ALLOC, 7'd1, 10'd0));         // grants block 0
    send_request(pack_request(OP_ALLOC, 7'd64, 10'd0));        // largest legal grant
    send_request(pack_request(OP_FREE, 7'd127, 10'd0));        // release block 0
    send_request(pack_request(OP_FREE, 7'd0, 10'd0));          // double free
    send_request(pack_request(OP_FREE, 7'd0, 10'd1023));       // free of a free block
    send_request(pack_request(OP_UNUSED, 7'd127, 10'd1023));   // acts as count
    // Fill the pool exactly; the first grant reuses the hole at block 0.
    repeat (15) send_request(pack_request(OP_ALLOC, 7'd64, 10'd0));
    send_request(pack_request(OP_ALLOC, 7'd1, 10'd0));         // no space, pool empty
    send_request(pack_request(OP_FREE, 7'd0, 10'd1023));       // last block back
    send_request(pack_request(OP_ALLOC, 7'd2, 10'd0));         // one short
    send_request(pack_request(OP_ALLOC, 7'd1, 10'd0));         // grants block 1023
    send_request(pack_request(OP_COUNT, 7'd0, 10'd0));

    // Random: frees punch holes across the map, allocs refill first-fit.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      quiet        <= (n >= 40 && n < 100);
      hold_request <= (n >= 150);
      req.request_count = CNT_W'($urandom);
      req.release_id    = ID_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) begin
        req.operation = OP_ALLOC;
        pick = $urandom_range(99);
        if (pick < 80)      req.request_count = CNT_W'($urandom_range(6, 1));
        else if (pick < 95) req.request_count = CNT_W'($urandom_range(64, 7));
        else if (pick < 97) req.request_count = '0;
        else                req.request_count = CNT_W'($urandom_range(127, 65));
      end else if (pick < 80) begin
        req.operation = OP_FREE;
      end else if (pick < 95) begin
        req.operation = OP_COUNT;
      end else begin
        req.operation = OP_UNUSED;
      end
      send_request(req);
    end
    in_valid <= 1'b0;

    // Drain: every expected result in, then a quiet tail for stray transactions.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
